// File: rtl/assert_macros.svh
// Assertion helpers; all properties are clocked on aclk and held off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dlt_pkg.sv
package dlt_pkg;

    localparam int unsigned CNT_W  = 9;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned ADDR_W = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = 9'd511;

    localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0D;

    localparam logic [ADDR_W-1:0] ADDR_LINE_OFFSET = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_CHAR_BUDGET = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_BYTE_LIMIT  = 4'h8;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_TERM = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [CNT_W-1:0]  count;
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  index;
    } result_t;

endpackage

// File: rtl/dbcs_line_truncator.sv
// Results are registered (output register, or skid entry while m_* stalls). Throughput:
// one source byte per cycle while s_tready is high; the output register plus a one-entry
// skid stage keep s_tready high while a result waits; only two stalled results block input.
// Reset (aresetn, synchronous, active low): registers and counters clear, the line
// starts finished and ignores bytes until a request with the start flag arrives.
`include "assert_macros.svh"

module dbcs_line_truncator (
    input  logic                      aclk,
    input  logic                      aresetn,
    // source byte channel
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] src_byte
    input  logic                      s_tuser,   // [0] start_flag
    // result channel
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               m_tdata,   // [8:0] dest_index, [16:9] dest_byte,
                                                 // [25:17] kept_count, [31:26] zero
    output logic                      m_tuser,   // [0] result_kind
    output logic                      m_tlast,   // last_flag
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [dlt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import dlt_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [BYTE_W-1:0] line_offset_reg;
    logic [BYTE_W-1:0] char_budget_reg;
    logic [BYTE_W-1:0] byte_limit_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_offset_reg <= '0;
            char_budget_reg <= '0;
            byte_limit_reg  <= '0;
        end else if (cfg_wr) begin
            case (paddr)
                ADDR_LINE_OFFSET: line_offset_reg <= pwdata[BYTE_W-1:0];
                ADDR_CHAR_BUDGET: char_budget_reg <= pwdata[BYTE_W-1:0];
                ADDR_BYTE_LIMIT:  byte_limit_reg  <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_LINE_OFFSET: prdata = {24'd0, line_offset_reg};
            ADDR_CHAR_BUDGET: prdata = {24'd0, char_budget_reg};
            ADDR_BYTE_LIMIT:  prdata = {24'd0, byte_limit_reg};
            default:          prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Line state
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] bytes_written_reg, bytes_written_next;
    logic [CNT_W-1:0] chars_used_reg, chars_used_next;
    logic             trail_pending_reg, trail_pending_next;
    logic             finished_reg, finished_next;

    logic             s_fire;
    logic             has_result;
    result_t          result;

    // start flag rewinds the line before this byte is handled
    logic [CNT_W-1:0] bw_cur, cu_cur;
    logic             trail_cur, fin_cur;

    // write position offset + 1 + written, and the two-byte fit test
    logic [CNT_W:0]   write_pos;
    logic [CNT_W:0]   pair_end;
    logic             room_ok, budget_ok, pair_over;
    logic [CNT_W:0]   bw_plus1, bw_plus2, cu_plus1, cu_plus2;
    logic [CNT_W-1:0] bw_sat1, bw_sat2, cu_sat1, cu_sat2;

    assign s_fire = s_tvalid && s_tready;

    always_comb begin
        bw_cur    = s_tuser ? '0 : bytes_written_reg;
        cu_cur    = s_tuser ? '0 : chars_used_reg;
        trail_cur = s_tuser ? 1'b0 : trail_pending_reg;
        fin_cur   = s_tuser ? 1'b0 : finished_reg;

        write_pos = {2'b00, line_offset_reg} + {1'b0, bw_cur} + 10'd1;
        pair_end  = {2'b00, line_offset_reg} + {1'b0, bw_cur} + 10'd2;
        room_ok   = write_pos < {2'b00, byte_limit_reg};
        budget_ok = cu_cur < {1'b0, char_budget_reg};
        pair_over = pair_end > {2'b00, byte_limit_reg};

        bw_plus1 = {1'b0, bw_cur} + 10'd1;
        bw_plus2 = {1'b0, bw_cur} + 10'd2;
        cu_plus1 = {1'b0, cu_cur} + 10'd1;
        cu_plus2 = {1'b0, cu_cur} + 10'd2;
        bw_sat1  = bw_plus1[CNT_W] ? CNT_MAX : bw_plus1[CNT_W-1:0];
        bw_sat2  = bw_plus2[CNT_W] ? CNT_MAX : bw_plus2[CNT_W-1:0];
        cu_sat1  = cu_plus1[CNT_W] ? CNT_MAX : cu_plus1[CNT_W-1:0];
        cu_sat2  = cu_plus2[CNT_W] ? CNT_MAX : cu_plus2[CNT_W-1:0];

        bytes_written_next = bw_cur;
        chars_used_next    = cu_cur;
        trail_pending_next = trail_cur;
        finished_next      = fin_cur;
        has_result         = 1'b0;
        result.kind        = KIND_DATA;
        result.index       = bw_cur;
        result.data        = s_tdata;
        result.count       = '0;

        if (fin_cur) begin
            // idle between lines: byte dropped
        end else if (trail_cur) begin
            // trail byte of a DBCS pair: written unchecked
            has_result         = 1'b1;
            result.index       = bw_plus1[CNT_W-1:0];
            trail_pending_next = 1'b0;
            bytes_written_next = bw_sat2;
            chars_used_next    = cu_sat2;
        end else if (!room_ok || !budget_ok) begin
            has_result         = 1'b1;
            result.kind        = KIND_TERM;
            result.data        = CHAR_NUL;
            result.count       = budget_ok ? bw_cur : '0;
            finished_next      = 1'b1;
        end else if (s_tdata == CHAR_NUL) begin
            has_result         = 1'b1;
            result.kind        = KIND_TERM;
            result.data        = CHAR_NUL;
            finished_next      = 1'b1;
        end else if (s_tdata[BYTE_W-1]) begin
            // lead byte: the whole pair must fit
            has_result = 1'b1;
            if (pair_over) begin
                result.kind   = KIND_TERM;
                result.data   = CHAR_NUL;
                result.count  = bw_cur;
                finished_next = 1'b1;
            end else begin
                trail_pending_next = 1'b1;
            end
        end else begin
            chars_used_next = cu_sat1;
            if (s_tdata != CHAR_CR && s_tdata != CHAR_LF) begin
                has_result         = 1'b1;
                bytes_written_next = bw_sat1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_written_reg <= '0;
            chars_used_reg    <= '0;
            trail_pending_reg <= 1'b0;
            finished_reg      <= 1'b1;
        end else if (s_fire) begin
            bytes_written_reg <= bytes_written_next;
            chars_used_reg    <= chars_used_next;
            trail_pending_reg <= trail_pending_next;
            finished_reg      <= finished_next;
        end
    end

    // ---------------------------------------------------------------
    // Output register with one skid entry
    // ---------------------------------------------------------------
    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;
    logic    push, pop;

    assign s_tready = !skid_valid_reg;
    assign push     = s_fire && has_result;
    assign pop      = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && !pop) begin
            if (push) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (skid_valid_reg) begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= push;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_valid_reg && !pop) begin
            if (push) begin
                skid_reg <= result;
            end
        end else if (skid_valid_reg) begin
            out_reg <= skid_reg;
        end else if (push) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.count, out_reg.data, out_reg.index};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = 1'b1;   // every request yields at most one result

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_reg || out_valid_reg, "skid full, output empty")
    `ASSERT_ALWAYS(a_trail_open_line, !trail_pending_reg || !finished_reg, "trail pending after finish")
    `ASSERT_ALWAYS(a_bytes_le_chars, bytes_written_reg <= chars_used_reg, "bytes exceed chars")
    `ASSERT_NEXT(a_term_finishes, push && result.kind == KIND_TERM, finished_reg, "terminator without finish")
    `ASSERT_NEXT(a_idle_drops, s_fire && finished_reg && !s_tuser, $stable(finished_reg) && !trail_pending_reg, "finished line moved")

endmodule

// File: dv/dbcs_line_truncator_tb.sv
`timescale 1ns / 100ps

module dbcs_line_truncator_tb;
    import dlt_pkg::*;

    // One result as seen on m_*: tuser, then the tdata fields, then tlast.
    typedef struct packed {
        logic              kind;
        logic [CNT_W-1:0]  index;
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  count;
        logic              last;
    } line_wr_t;

    typedef enum logic [1:0] {
        ROW_BYTE,   // send one source byte request
        ROW_REG     // write one register while idle
    } row_op_t;

    // Directed row. When chk is set, the expected result is typed in here
    // (hit says whether there is one at all); otherwise the predictor decides.
    typedef struct packed {
        row_op_t           op;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        val;
        logic              start;
        logic              chk;
        logic              hit;
        line_wr_t          res;
    } dir_row_t;

    localparam int HOLD_CYC    = 400;   // receiver back-pressure stretch
    localparam int STUCK_LIMIT = 3000;  // cycles with no handshake at all
    localparam int IDLE_PCT    = 7;
    localparam int RAND_ITEMS  = 1025;
    localparam int PHASE_ITEMS = 80;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = '0;   // [7:0] src_byte
    logic              s_tuser  = 1'b0; // [0] start_flag
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;         // [8:0] dest_index, [16:9] dest_byte,
                                        // [25:17] kept_count, [31:26] zero
    logic              m_tuser;         // [0] result_kind
    logic              m_tlast;         // last_flag
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Predictor copy of the registers and the line state.
    logic [7:0]       line_off   = '0;
    logic [7:0]       chr_budget = '0;
    logic [7:0]       byte_lim   = '0;
    logic [CNT_W-1:0] wr_cnt     = '0;
    logic [CNT_W-1:0] chr_cnt    = '0;
    logic             trail_wait = 1'b0;
    logic             line_done  = 1'b1;   // idle until the first start

    line_wr_t dest_wr_q[$];   // expected destination writes, oldest first
    line_wr_t want_wr;

    int  errs      = 0;
    int  stuck     = 0;
    int  hold_left = 0;
    bit  hold_ask  = 0;   // stimulus asks the receiver for one long stall
    bit  hold_done = 0;
    bit  calm      = 0;   // no idling on either side while set

    dbcs_line_truncator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a, input int inc);
        int s;
        s = int'(a) + inc;
        return (s > int'(CNT_MAX)) ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    // Terminator write at the current position; the line goes idle.
    function automatic line_wr_t close_line(input logic [CNT_W-1:0] cnt);
        line_wr_t r;
        line_done  = 1'b1;
        trail_wait = 1'b0;
        r.kind  = KIND_TERM;
        r.index = wr_cnt;
        r.data  = '0;
        r.count = cnt;
        r.last  = 1'b1;
        return r;
    endfunction

    // Advances the line state by one source byte; returns 1 if a write results.
    function automatic bit truncate_step(input logic [7:0] b, input logic st,
                                         output line_wr_t r);
        int pos;
        r = '0;
        r.last = 1'b1;
        // start wins over everything, a pending trail byte included
        if (st) begin
            wr_cnt     = '0;
            chr_cnt    = '0;
            trail_wait = 1'b0;
            line_done  = 1'b0;
        end
        if (line_done)
            return 1'b0;
        // trail byte: no limit check, any value goes through
        if (trail_wait) begin
            r.kind     = KIND_DATA;
            r.index    = wr_cnt + 9'd1;
            r.data     = b;
            trail_wait = 1'b0;
            wr_cnt     = sat_add(wr_cnt, 2);
            chr_cnt    = sat_add(chr_cnt, 2);
            return 1'b1;
        end
        pos = int'(line_off) + 1 + int'(wr_cnt);
        if (pos >= int'(byte_lim) || chr_cnt >= chr_budget) begin
            // budget exhaustion reports zero kept bytes
            r = close_line((chr_cnt >= chr_budget) ? 9'd0 : wr_cnt);
            return 1'b1;
        end
        if (b == CHAR_NUL) begin
            r = close_line(9'd0);
            return 1'b1;
        end
        if (b[7]) begin
            // lead byte: the pair must fit as a whole
            if (int'(line_off) + int'(wr_cnt) + 2 > int'(byte_lim)) begin
                r = close_line(wr_cnt);
                return 1'b1;
            end
            trail_wait = 1'b1;
            r.kind     = KIND_DATA;
            r.index    = wr_cnt;
            r.data     = b;
            return 1'b1;
        end
        chr_cnt = sat_add(chr_cnt, 1);
        // bare line breaks are consumed without a write
        if (b == CHAR_CR || b == CHAR_LF)
            return 1'b0;
        r.kind  = KIND_DATA;
        r.index = wr_cnt;
        r.data  = b;
        wr_cnt  = sat_add(wr_cnt, 1);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Offers one byte request, holds it until accepted, then books the
    // expectation.
    task automatic push_byte(input logic [7:0] b, input logic st, input logic chk,
                             input logic hit, input line_wr_t res);
        line_wr_t pred;
        bit       got;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        do @(posedge aclk); while (!s_tready);
        got = truncate_step(b, st, pred);
        if (chk) begin
            if (hit)
                dest_wr_q.push_back(res);
        end else if (got) begin
            dest_wr_q.push_back(pred);
        end
    endtask

    // Stop offering and wait until every booked write has come out, then wait
    // out a byte that is still in flight but produces nothing.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (dest_wr_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Setup phase, access phase, then psel and penable drop before the task returns, so
    // back-to-back writes never touch psel twice in one step.
    task automatic reg_write(input logic [ADDR_W-1:0] a, input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= {24'h0, v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (a)
            ADDR_LINE_OFFSET: line_off   = v;
            ADDR_CHAR_BUDGET: chr_budget = v;
            ADDR_BYTE_LIMIT:  byte_lim   = v;
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Register value: zero, full scale, anything, or a moderate pick that
    // keeps lines going for a while.
    function automatic logic [7:0] pick_reg(input int lo, input int hi);
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(lo, hi));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    localparam line_wr_t NO_WR = '0;

    dir_row_t dir_tab [25] = '{
        // ignored: the line starts finished
        '{ROW_BYTE, '0, 8'h41, 1'b0, 1'b1, 1'b0, NO_WR},
        // zero budget after reset: immediate terminator, count zero
        '{ROW_BYTE, '0, 8'h41, 1'b1, 1'b1, 1'b1, '{KIND_TERM, 9'd0, 8'h00, 9'd0, 1'b1}},
        '{ROW_REG, ADDR_CHAR_BUDGET, 8'd255, 1'b0, 1'b0, 1'b0, NO_WR},
        '{ROW_REG, ADDR_BYTE_LIMIT,  8'd255, 1'b0, 1'b0, 1'b0, NO_WR},
        '{ROW_BYTE, '0, 8'h41, 1'b1, 1'b1, 1'b1, '{KIND_DATA, 9'd0, 8'h41, 9'd0, 1'b1}},
        // lead byte, then a NUL trail that must still be written
        '{ROW_BYTE, '0, 8'hFF, 1'b0, 1'b1, 1'b1, '{KIND_DATA, 9'd1, 8'hFF, 9'd0, 1'b1}},
        '{ROW_BYTE, '0, 8'h00, 1'b0, 1'b1, 1'b1, '{KIND_DATA, 9'd2, 8'h00, 9'd0, 1'b1}},
        // bare line breaks: consumed, nothing written
        '{ROW_BYTE, '0, CHAR_CR, 1'b0, 1'b1, 1'b0, NO_WR},
        '{ROW_BYTE, '0, CHAR_LF, 1'b0, 1'b1, 1'b0, NO_WR},
        '{ROW_BYTE, '0, 8'h7F, 1'b0, 1'b0, 1'b0, NO_WR},
        '{ROW_BYTE, '0, 8'h80, 1'b0, 1'b0, 1'b0, NO_WR},
        // start while a trail byte is pending
        '{ROW_BYTE, '0, 8'h42, 1'b1, 1'b1, 1'b1, '{KIND_DATA, 9'd0, 8'h42, 9'd0, 1'b1}},
        // NUL ends the line early with count zero
        '{ROW_BYTE, '0, CHAR_NUL, 1'b0, 1'b1, 1'b1, '{KIND_TERM, 9'd1, 8'h00, 9'd0, 1'b1}},
        '{ROW_BYTE, '0, 8'h55, 1'b0, 1'b1, 1'b0, NO_WR},
        // narrow row: pair just fits, then byte limit stops with the count
        '{ROW_REG, ADDR_LINE_OFFSET, 8'd2, 1'b0, 1'b0, 1'b0, NO_WR},
        '{ROW_REG, ADDR_BYTE_LIMIT,  8'd5, 1'b0, 1'b0, 1'b0, NO_WR},
        '{ROW_BYTE, '0, 8'h61, 1'b1, 1'b0, 1'b0, NO_WR},
        '{ROW_BYTE, '0, 8'h9A, 1'b0, 1'b0, 1'b0, NO_WR},
        '{ROW_BYTE, '0, 8'hB1, 1'b0, 1'b0, 1'b0, NO_WR},
        '{ROW_BYTE, '0, 8'h7A, 1'b0, 1'b1, 1'b1, '{KIND_TERM, 9'd3, 8'h00, 9'd3, 1'b1}},
        // char budget of one: second char hits it, count zero
        '{ROW_REG, ADDR_CHAR_BUDGET, 8'd1, 1'b0, 1'b0, 1'b0, NO_WR},
        '{ROW_BYTE, '0, 8'h71, 1'b1, 1'b0, 1'b0, NO_WR},
        '{ROW_BYTE, '0, 8'h72, 1'b0, 1'b1, 1'b1, '{KIND_TERM, 9'd1, 8'h00, 9'd0, 1'b1}},
        // full offset: no room at all on the row
        '{ROW_REG, ADDR_LINE_OFFSET, 8'd255, 1'b0, 1'b0, 1'b0, NO_WR},
        '{ROW_BYTE, '0, 8'h78, 1'b1, 1'b1, 1'b1, '{KIND_TERM, 9'd0, 8'h00, 9'd0, 1'b1}}
    };

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        bit         gen_trail;
        int         sent_cnt;
        int         phase;
        int         line_left;
        int         pick;
        int         lim_lo;
        int         lim_hi;
        logic [7:0] b;
        logic       st;

        sent_cnt  = 0;
        phase     = 0;
        line_left = 0;
        gen_trail = 0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].op == ROW_REG) begin
                settle();
                reg_write(dir_tab[i].addr, dir_tab[i].val);
            end else begin
                push_byte(dir_tab[i].val, dir_tab[i].start, dir_tab[i].chk,
                          dir_tab[i].hit, dir_tab[i].res);
            end
        end

        // Random phases: mostly text lines (ASCII, line breaks, DBCS pairs,
        // the odd NUL) under fresh register settings, with some raw noise
        // and stray starts that cut lines and pairs short.
        while (sent_cnt < RAND_ITEMS && phase < 60) begin
            settle();
            calm = (phase == 2);
            if (phase == 0 || $urandom_range(0, 2) != 0)
                reg_write(ADDR_LINE_OFFSET, pick_reg(0, 16));
            if (phase == 0 || $urandom_range(0, 2) != 0)
                reg_write(ADDR_CHAR_BUDGET, pick_reg(8, 80));
            if (phase == 0 || $urandom_range(0, 2) != 0) begin
                lim_lo = (int'(line_off) + 4 > 255) ? 255 : int'(line_off) + 4;
                lim_hi = (int'(line_off) + 120 > 255) ? 255 : int'(line_off) + 120;
                reg_write(ADDR_BYTE_LIMIT, pick_reg(lim_lo, lim_hi));
            end
            // receiver stalls for a long stretch while we keep offering
            if (phase == 4)
                hold_ask = 1;

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                st = 1'b0;
                if (line_left == 0) begin
                    st        = 1'b1;
                    line_left = $urandom_range(3, 70);
                end else if ($urandom_range(0, 49) == 0) begin
                    st = 1'b1;
                end
                line_left--;
                if (gen_trail) begin
                    b         = 8'($urandom_range(0, 255));
                    gen_trail = 0;
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 55) begin
                        b = 8'($urandom_range(8'h20, 8'h7E));
                    end else if (pick < 62) begin
                        b = pick[0] ? CHAR_CR : CHAR_LF;
                    end else if (pick < 84) begin
                        b         = 8'($urandom_range(8'h80, 8'hFF));
                        gen_trail = 1;
                    end else if (pick < 87) begin
                        b = CHAR_NUL;
                    end else begin
                        b = 8'($urandom_range(0, 255));
                    end
                end
                // sender stops mid-stream until everything has drained
                if (phase == 6 && i == PHASE_ITEMS / 2)
                    settle();
                push_byte(b, st, 1'b0, 1'b0, NO_WR);
                sent_cnt++;
            end
            phase++;
        end

        settle();
        if (errs == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver side: random idling, plus one long stall on request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_ask && !hold_done) begin
            hold_done <= 1;
            hold_left <= HOLD_CYC;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (dest_wr_q.size() == 0) begin
                $error("unexpected result: kind %0d index %0d byte 0x%02h count %0d",
                       m_tuser, m_tdata[8:0], m_tdata[16:9], m_tdata[25:17]);
                errs++;
            end else begin
                want_wr = dest_wr_q.pop_front();
                if (m_tuser !== want_wr.kind) begin
                    $error("result_kind: expected %0d, got %0d", want_wr.kind, m_tuser);
                    errs++;
                end
                if (m_tdata[8:0] !== want_wr.index) begin
                    $error("dest_index: expected %0d, got %0d", want_wr.index, m_tdata[8:0]);
                    errs++;
                end
                if (m_tdata[16:9] !== want_wr.data) begin
                    $error("dest_byte: expected 0x%02h, got 0x%02h",
                           want_wr.data, m_tdata[16:9]);
                    errs++;
                end
                if (m_tdata[25:17] !== want_wr.count) begin
                    $error("kept_count: expected %0d, got %0d", want_wr.count, m_tdata[25:17]);
                    errs++;
                end
                if (m_tlast !== want_wr.last) begin
                    $error("last_flag: expected %0d, got %0d", want_wr.last, m_tlast);
                    errs++;
                end
                if (m_tdata[31:26] !== 6'd0) begin
                    $error("tdata pad: expected 0, got 0x%02h", m_tdata[31:26]);
                    errs++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any handshake on any port ends the run
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            stuck <= 0;
        end else if (stuck >= STUCK_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            stuck <= stuck + 1;
        end
    end

endmodule

// File: dbcs_line_truncator.f
+incdir+rtl
rtl/dlt_pkg.sv
rtl/dbcs_line_truncator.sv
dv/dbcs_line_truncator_tb.sv
